### design/lru_pkg.sv
`timescale 1ns / 1ps
// shared constants for the mru ordered key list
// no dependencies; imported by the interfaces, the key ram, the top level, the checkers and the testbench
package lru_pkg;

	localparam int DEPTH_DEF = 8;
	localparam int KEY_W     = 64;
	localparam int MAX_W     = 4;
	localparam int OCC_W     = 4;

	localparam logic [MAX_W-1:0] MAX_RESET = 4'd8;

	// operation codes
	localparam logic OP_ACCESS = 1'b0;
	localparam logic OP_CLOSE  = 1'b1;

endpackage

### design/lru_in_if.sv
`timescale 1ns / 1ps
// request channel: one operation and key per word
// depends on lru_pkg
interface lru_in_if import lru_pkg::*; ();

	logic             valid;
	logic             ready;
	logic             operation;
	logic [KEY_W-1:0] key;

	modport source (output valid, output operation, output key, input ready);
	modport sink   (input valid, input operation, input key, output ready);

endinterface

### design/lru_out_if.sv
`timescale 1ns / 1ps
// result channel: hit, eviction report and occupancy per word
// depends on lru_pkg
interface lru_out_if import lru_pkg::*; ();

	logic             valid;
	logic             ready;
	logic             hit;
	logic             evicted_valid;
	logic [KEY_W-1:0] evicted_key;
	logic [OCC_W-1:0] occupancy;

	modport source (output valid, output hit, output evicted_valid, output evicted_key,
		output occupancy, input ready);
	modport sink   (input valid, input hit, input evicted_valid, input evicted_key,
		input occupancy, output ready);

endinterface

### design/lru_key_ram.sv
`timescale 1ns / 1ps
// key storage: one write port, one read port with registered read data
// depends on lru_pkg
module lru_key_ram import lru_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int AW    = 3
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [KEY_W-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [KEY_W-1:0] rdata
);

	logic [KEY_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### design/lru_open_entry_tracker.sv
`timescale 1ns / 1ps
// sequence, accept to result word: each slot is read and then compared (one more step when the
// search runs past the last slot), each slot moved is read and then written, an access that moves
// its key writes it to the front slot, and the result register loads last
// throughput: one word at a time, ready for the next in the cycle after the previous result loads; a result
// word still held back stalls the load; the shared key ram port and comparator set the pace
// reset: asynchronous, clears sequencer, entry count, result valid; max_entries goes to 8
module lru_open_entry_tracker import lru_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [MAX_W-1:0] cfg_wdata,
	lru_in_if.sink           request,
	lru_out_if.source        result
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int LW = (CW > MAX_W) ? CW : MAX_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RD    = 3'd1;
	localparam logic [2:0] ST_CMP   = 3'd2;
	localparam logic [2:0] ST_MRD   = 3'd3;
	localparam logic [2:0] ST_MWR   = 3'd4;
	localparam logic [2:0] ST_FRONT = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0]       state_q;
	logic [MAX_W-1:0] max_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    idx_q;
	logic [AW-1:0]    dst_q;
	logic [AW-1:0]    lim_q;
	logic             dir_down_q;
	logic             op_q;
	logic [KEY_W-1:0] key_q;
	logic             hit_q;
	logic             ev_q;
	logic [KEY_W-1:0] evk_q;

	logic             out_valid_q;
	logic             out_hit_q;
	logic             out_ev_q;
	logic [KEY_W-1:0] out_evk_q;
	logic [OCC_W-1:0] out_occ_q;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [KEY_W-1:0] ram_wdata;
	logic             ram_re;
	logic [AW-1:0]    ram_raddr;
	logic [KEY_W-1:0] ram_rdata;

	logic             search_end;
	logic             match;
	logic             decide;
	logic             found;
	logic [CW-1:0]    pos;
	logic [LW-1:0]    limit;
	logic             full;
	logic [AW-1:0]    src;

	logic [2:0]       dec_state;
	logic [AW-1:0]    dec_dst;
	logic [AW-1:0]    dec_lim;
	logic             dec_down;
	logic [CW-1:0]    dec_count;
	logic             dec_ev;

	lru_key_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// search status and clamped limit
	always_comb begin
		search_end = (idx_q == count_q);
		match      = (ram_rdata == key_q);
		decide     = ((state_q == ST_RD) && search_end) || ((state_q == ST_CMP) && match);
		found      = (state_q == ST_CMP);
		pos        = idx_q;
		if (max_q == '0) begin
			limit = LW'(1);
		end else if (LW'(max_q) > LW'(DEPTH)) begin
			limit = LW'(DEPTH);
		end else begin
			limit = LW'(max_q);
		end
		full = (LW'(count_q) >= limit);
		src  = dir_down_q ? (dst_q - AW'(1)) : (dst_q + AW'(1));
	end

	// plan of the list update once the search is over
	always_comb begin
		dec_state = ST_DONE;
		dec_dst   = pos[AW-1:0];
		dec_lim   = '0;
		dec_down  = 1'b1;
		dec_count = count_q;
		dec_ev    = 1'b0;
		if (op_q == OP_CLOSE) begin
			if (found) begin
				dec_count = count_q - CW'(1);
				if ((pos + CW'(1)) < count_q) begin
					dec_state = ST_MRD;
					dec_down  = 1'b0;
					dec_lim   = AW'(count_q - CW'(2));
				end
			end
		end else if (found) begin
			if (pos != '0) begin
				dec_state = ST_MRD;
			end
		end else begin
			if (full) begin
				dec_ev  = 1'b1;
				dec_dst = AW'(count_q - CW'(1));
			end else begin
				dec_count = count_q + CW'(1);
				dec_dst   = AW'(count_q);
			end
			dec_state = (dec_dst == '0) ? ST_FRONT : ST_MRD;
		end
	end

	// key ram port use per state
	always_comb begin
		ram_re    = ((state_q == ST_RD) && !search_end) || (state_q == ST_MRD);
		ram_raddr = (state_q == ST_RD) ? idx_q[AW-1:0] : src;
		ram_we    = (state_q == ST_MWR) || (state_q == ST_FRONT);
		ram_waddr = (state_q == ST_FRONT) ? '0 : dst_q;
		ram_wdata = (state_q == ST_FRONT) ? key_q : ram_rdata;
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_RESET;
		end else if (cfg_we) begin
			max_q <= cfg_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && (!out_valid_q || result.ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (request.valid) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					if (decide) begin
						state_q <= dec_state;
						count_q <= dec_count;
					end else begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (decide) begin
						state_q <= dec_state;
						count_q <= dec_count;
					end else begin
						state_q <= ST_RD;
					end
				end
				ST_MRD: begin
					state_q <= ST_MWR;
				end
				ST_MWR: begin
					if (dir_down_q) begin
						state_q <= (dst_q == AW'(1)) ? ST_FRONT : ST_MRD;
					end else begin
						state_q <= (dst_q == lim_q) ? ST_DONE : ST_MRD;
					end
				end
				ST_FRONT: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || result.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// per-word working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				op_q  <= request.operation;
				key_q <= request.key;
				idx_q <= '0;
			end
			ST_RD, ST_CMP: begin
				if (state_q == ST_CMP) begin
					evk_q <= ram_rdata;
				end
				if (decide) begin
					hit_q      <= found;
					ev_q       <= dec_ev;
					dst_q      <= dec_dst;
					lim_q      <= dec_lim;
					dir_down_q <= dec_down;
				end else if (state_q == ST_CMP) begin
					idx_q <= idx_q + CW'(1);
				end
			end
			ST_MWR: begin
				dst_q <= src;
			end
			default: begin
			end
		endcase
	end

	// result word register
	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && (!out_valid_q || result.ready)) begin
			out_hit_q <= hit_q;
			out_ev_q  <= ev_q;
			out_evk_q <= ev_q ? evk_q : '0;
			out_occ_q <= OCC_W'(count_q);
		end
	end

	assign request.ready        = (state_q == ST_IDLE);
	assign result.valid         = out_valid_q;
	assign result.hit           = out_hit_q;
	assign result.evicted_valid = out_ev_q;
	assign result.evicted_key   = out_evk_q;
	assign result.occupancy     = out_occ_q;

endmodule

### design/lru_checker.sv
`timescale 1ns / 1ps
// port-level checks of the mru key list, bound to the top level
// depends on lru_pkg and lru_open_entry_tracker
module lru_checker import lru_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input logic             clk,
	input logic             arst_n,
	input logic             res_valid,
	input logic             res_ready,
	input logic             res_hit,
	input logic             res_ev,
	input logic [KEY_W-1:0] res_evk,
	input logic [OCC_W-1:0] res_occ
);

	// a result word waits until it is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result word dropped before it was taken");

	// only a miss can evict
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ev |-> !res_hit)
		else $error("eviction reported on a hit");

	// evicted key reads zero without an eviction
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ev |-> (res_evk == '0))
		else $error("evicted key nonzero without eviction");

	// occupancy never exceeds the list depth (checked for depths up to 15)
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((DEPTH > 15) || (int'(res_occ) <= DEPTH)))
		else $error("occupancy above list depth");

endmodule

bind lru_open_entry_tracker lru_checker #(.DEPTH(DEPTH)) u_lru_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_hit   (result.hit),
	.res_ev    (result.evicted_valid),
	.res_evk   (result.evicted_key),
	.res_occ   (result.occupancy)
);

### verif/lru_open_entry_tracker_checker.sv
`timescale 1ns / 1ps
// result checker for the mru ordered key list: tracks the list, predicts every result word
// depends on lru_pkg, lru_in_if and lru_out_if
module lru_open_entry_tracker_checker import lru_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [MAX_W-1:0] cfg_wdata,
	lru_in_if                request,
	lru_out_if               result,
	output int               fail_count,
	output int               pending_count
);

	typedef struct packed {
		logic             hit;
		logic             evicted_valid;
		logic [KEY_W-1:0] evicted_key;
		logic [OCC_W-1:0] occupancy;
	} lru_result_t;

	logic [KEY_W-1:0] mru_keys [DEPTH];
	int unsigned      mru_count;
	logic [MAX_W-1:0] max_entries_cfg;
	lru_result_t      expected_results [$];

	// slots in use before eviction, clamped to 1..DEPTH
	function automatic int unsigned slot_limit();
		int unsigned lim;
		lim = max_entries_cfg;
		if (lim < 1) lim = 1;
		if (lim > DEPTH) lim = DEPTH;
		return lim;
	endfunction

	// apply one operation to the tracked list and work out its result word
	task automatic update_mru_list(input logic op, input logic [KEY_W-1:0] key,
		output lru_result_t res);
		int unsigned pos;
		logic        found;
		pos = mru_count;
		for (int unsigned i = 0; i < mru_count; i++) begin
			if (mru_keys[i] == key) begin
				pos = i;
				break;
			end
		end
		found = (pos < mru_count);
		res = '0;
		res.hit = found;
		if (op == OP_CLOSE) begin
			// remove the key and close the gap behind it
			if (found) begin
				for (int unsigned i = pos; i + 1 < mru_count; i++)
					mru_keys[i] = mru_keys[i + 1];
				mru_count--;
			end
		end else if (found) begin
			// move to front, keys ahead of it shift back
			for (int unsigned i = pos; i > 0; i--)
				mru_keys[i] = mru_keys[i - 1];
			mru_keys[0] = key;
		end else if (mru_count < slot_limit()) begin
			// room left: insert at the front
			for (int unsigned i = mru_count; i > 0; i--)
				mru_keys[i] = mru_keys[i - 1];
			mru_keys[0] = key;
			mru_count++;
		end else begin
			// full list: tail key goes out, new key in at the front
			res.evicted_valid = 1'b1;
			res.evicted_key = mru_keys[mru_count - 1];
			for (int unsigned i = mru_count - 1; i > 0; i--)
				mru_keys[i] = mru_keys[i - 1];
			mru_keys[0] = key;
		end
		res.occupancy = mru_count[OCC_W-1:0];
	endtask

	// compare one received result word with the oldest prediction
	task automatic compare_word(input lru_result_t got);
		lru_result_t exp;
		if (expected_results.size() == 0) begin
			$display("%0t: unexpected result word hit=%0b ev=%0b key=%h occ=%0d", $time,
				got.hit, got.evicted_valid, got.evicted_key, got.occupancy);
			fail_count++;
			return;
		end
		exp = expected_results.pop_front();
		if (got.hit !== exp.hit) begin
			$display("%0t: hit expected %0b actual %0b", $time, exp.hit, got.hit);
			fail_count++;
		end
		if (got.evicted_valid !== exp.evicted_valid) begin
			$display("%0t: evicted_valid expected %0b actual %0b", $time,
				exp.evicted_valid, got.evicted_valid);
			fail_count++;
		end
		if (got.evicted_key !== exp.evicted_key) begin
			$display("%0t: evicted_key expected %h actual %h", $time,
				exp.evicted_key, got.evicted_key);
			fail_count++;
		end
		if (got.occupancy !== exp.occupancy) begin
			$display("%0t: occupancy expected %0d actual %0d", $time,
				exp.occupancy, got.occupancy);
			fail_count++;
		end
	endtask

	// watch both channels and the register port on every rising edge
	always @(posedge clk or negedge arst_n) begin
		lru_result_t got;
		lru_result_t pred;
		if (!arst_n) begin
			mru_count = 0;
			max_entries_cfg = MAX_RESET;
			expected_results.delete();
			fail_count = 0;
			pending_count = 0;
		end else begin
			if (result.valid === 1'b1 && result.ready === 1'b1) begin
				got.hit = result.hit;
				got.evicted_valid = result.evicted_valid;
				got.evicted_key = result.evicted_key;
				got.occupancy = result.occupancy;
				compare_word(got);
			end
			if (request.valid === 1'b1 && request.ready === 1'b1) begin
				update_mru_list(request.operation, request.key, pred);
				expected_results.push_back(pred);
			end
			if (cfg_we)
				max_entries_cfg = cfg_wdata;
			pending_count = expected_results.size();
		end
	end

endmodule

### verif/lru_open_entry_tracker_tb.sv
`timescale 1ns / 1ps
// testbench top for lru_open_entry_tracker: clock, reset, request and register stimulus, verdict
// depends on lru_pkg, lru_in_if, lru_out_if, the block and lru_open_entry_tracker_checker
module lru_open_entry_tracker_tb;
	import lru_pkg::*;

	localparam int POOL_SIZE    = 12;
	localparam int PHASE_WORDS  = 125;
	localparam int SETTLE_CYCLE = 4 * DEPTH_DEF + 8;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [MAX_W-1:0] cfg_wdata;
	logic             quiet;
	int               fail_count;
	int               pending_count;
	logic [KEY_W-1:0] key_pool [POOL_SIZE];
	logic [MAX_W-1:0] phase_limits [12] = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6,
		4'd7, 4'd8, 4'd9, 4'd15, 4'd8};

	lru_in_if  req_ch ();
	lru_out_if res_ch ();

	lru_open_entry_tracker uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.request   (req_ch),
		.result    (res_ch)
	);

	lru_open_entry_tracker_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.request       (req_ch),
		.result        (res_ch),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// result side back-pressure
	always @(negedge clk)
		res_ch.ready <= quiet || ($urandom_range(99) >= 34);

	// run limit
	initial begin
		#(5_000_000);
		$display("** lru_open_entry_tracker: FAILED **");
		$finish;
	end

	// offer one request word, called and returning at a falling edge
	task automatic send_word(input logic op, input logic [KEY_W-1:0] key);
		while (!quiet && $urandom_range(99) < 34) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.operation <= op;
		req_ch.key <= key;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		@(negedge clk);
	endtask

	// stop offering and wait until every result word is back
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (SETTLE_CYCLE) @(negedge clk);
	endtask

	task automatic write_max_entries(input logic [MAX_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly pool keys so the list sees hits, some fully random ones
	function automatic logic [KEY_W-1:0] pick_key();
		if ($urandom_range(99) < 85)
			return key_pool[$urandom_range(POOL_SIZE - 1)];
		return {$urandom, $urandom};
	endfunction

	initial begin
		logic [KEY_W-1:0] base_key;
		logic             op;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		quiet = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.operation = OP_ACCESS;
		req_ch.key = '0;
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			key_pool[i] = {$urandom, $urandom};
		base_key = 64'h0123_4567_89ab_cde0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty list, move to front, front hit, closes, fill and evict
		send_word(OP_ACCESS, '0);
		send_word(OP_ACCESS, '1);
		send_word(OP_ACCESS, '0);
		send_word(OP_ACCESS, '0);
		send_word(OP_CLOSE, '1);
		send_word(OP_CLOSE, 64'h5555_aaaa_5555_aaaa);
		send_word(OP_CLOSE, '0);
		send_word(OP_CLOSE, '0);
		for (int i = 0; i < 9; i++)
			send_word(OP_ACCESS, base_key + i);
		send_word(OP_ACCESS, base_key + 4);
		send_word(OP_CLOSE, base_key + 6);

		// limit lowered under the current occupancy
		drain_results();
		write_max_entries(4'd2);
		send_word(OP_ACCESS, '0);
		send_word(OP_CLOSE, base_key + 4);
		drain_results();

		// random phases, one limit each, one phase with no idling
		for (int ph = 0; ph < 12; ph++) begin
			write_max_entries(phase_limits[ph]);
			quiet = (ph == 6);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				op = ($urandom_range(99) < 30) ? OP_CLOSE : OP_ACCESS;
				send_word(op, pick_key());
			end
			drain_results();
		end
		quiet = 1'b0;

		if (fail_count == 0)
			$display("** lru_open_entry_tracker: PASSED **");
		else
			$display("** lru_open_entry_tracker: FAILED **");
		$finish;
	end

endmodule
